// File: src/resistance_slew_limiter_macros.svh
// ----------------------------------------------------------------------------
// Resistance slew limiter assertion macros
// Shared concurrent assertion forms used by the limiter RTL.
// ----------------------------------------------------------------------------
`ifndef RESISTANCE_SLEW_LIMITER_MACROS_SVH
`define RESISTANCE_SLEW_LIMITER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RSL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/rsl_pkg.sv
// ----------------------------------------------------------------------------
// Resistance slew limiter package
// Widths, reset values, register indexes and payload types of the limiter.
// ----------------------------------------------------------------------------
package rsl_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned StepWidth  = 24;
   localparam int unsigned CountWidth = 8;
   localparam int unsigned RangeWidth = 2;
   localparam int unsigned IndexWidth = 2;

   localparam logic [StepWidth-1:0]  LargeStepReset   = 24'd5000;
   localparam logic [StepWidth-1:0]  SmallStepReset   = 24'd100;
   localparam logic [CountWidth-1:0] SmoothCountReset = 8'd64;
   localparam logic [CountWidth-1:0] MaskCountReset   = 8'd6;

   localparam logic [ValueWidth-1:0] MarkerCode = 32'hFFFF_FFFF;
   localparam logic [ValueWidth-1:0] StartValue = 32'd10_000_000;

   localparam logic [IndexWidth-1:0] RegLargeStep   = 2'd0;
   localparam logic [IndexWidth-1:0] RegSmallStep   = 2'd1;
   localparam logic [IndexWidth-1:0] RegSmoothCount = 2'd2;
   localparam logic [IndexWidth-1:0] RegMaskCount   = 2'd3;

   localparam logic KindSample  = 1'b0;
   localparam logic KindRestart = 1'b1;

   typedef struct packed {
      logic [StepWidth-1:0]  large_step;
      logic [StepWidth-1:0]  small_step;
      logic [CountWidth-1:0] smooth_count;
      logic [CountWidth-1:0] mask_count;
   } cfg_type;

   typedef struct packed {
      logic                  kind;
      logic [ValueWidth-1:0] resistance;
      logic [RangeWidth-1:0] range;
   } req_type;

   typedef struct packed {
      logic [ValueWidth-1:0] limited_value;
      logic                  masked;
   } rsp_type;

endpackage

// File: src/rsl_if.sv
// ----------------------------------------------------------------------------
// Resistance slew limiter channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface rsl_req_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [rsl_pkg::ValueWidth-1:0] resistance;
   logic [rsl_pkg::RangeWidth-1:0] range;

   modport source (output valid, kind, resistance, range, input ready);
   modport sink (input valid, kind, resistance, range, output ready);
endinterface

interface rsl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rsl_pkg::ValueWidth-1:0] limited_value;
   logic                           masked;

   modport source (output valid, limited_value, masked, input ready);
   modport sink (input valid, limited_value, masked, output ready);
endinterface

interface rsl_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rsl_pkg::IndexWidth-1:0] index;
   logic [rsl_pkg::StepWidth-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: src/rsl_csr.sv
// ----------------------------------------------------------------------------
// Resistance slew limiter registers
// Holds the step and count registers written through the register channel.
// ----------------------------------------------------------------------------
module rsl_csr (
   input  logic              clock,
   input  logic              reset,
   rsl_csr_if.sink           csr_bus,
   output rsl_pkg::cfg_type  cfg
);

   rsl_pkg::cfg_type cfg_ff;
   rsl_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            rsl_pkg::RegLargeStep: begin
               cfg_in.large_step = csr_bus.data;
            end
            rsl_pkg::RegSmallStep: begin
               cfg_in.small_step = csr_bus.data;
            end
            rsl_pkg::RegSmoothCount: begin
               cfg_in.smooth_count = csr_bus.data[rsl_pkg::CountWidth-1:0];
            end
            rsl_pkg::RegMaskCount: begin
               cfg_in.mask_count = csr_bus.data[rsl_pkg::CountWidth-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.large_step   <= rsl_pkg::LargeStepReset;
         cfg_ff.small_step   <= rsl_pkg::SmallStepReset;
         cfg_ff.smooth_count <= rsl_pkg::SmoothCountReset;
         cfg_ff.mask_count   <= rsl_pkg::MaskCountReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/rsl_core.sv
// ----------------------------------------------------------------------------
// Resistance slew limiter core
// Tracks range, step and counters and forms the limited value of a sample.
// ----------------------------------------------------------------------------
`include "resistance_slew_limiter_macros.svh"

module rsl_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  rsl_pkg::req_type req,
   input  rsl_pkg::cfg_type cfg,
   output logic             res_valid,
   output rsl_pkg::rsp_type res
);

   logic [rsl_pkg::RangeWidth-1:0] prev_range_ff, prev_range_in;
   logic                           have_first_ff, have_first_in;
   logic [rsl_pkg::CountWidth-1:0] mask_left_ff, mask_left_in;
   logic [rsl_pkg::CountWidth-1:0] smooth_left_ff, smooth_left_in;
   logic [rsl_pkg::StepWidth-1:0]  step_now_ff, step_now_in;
   logic [rsl_pkg::ValueWidth-1:0] kept_value_ff, kept_value_in;

   logic                           range_change;
   logic [rsl_pkg::CountWidth-1:0] mask_base;
   logic [rsl_pkg::CountWidth-1:0] smooth_base;
   logic [rsl_pkg::CountWidth-1:0] smooth_next;
   logic [rsl_pkg::StepWidth-1:0]  step_base;
   logic [rsl_pkg::StepWidth-1:0]  step_eff;
   logic [rsl_pkg::ValueWidth-1:0] step_wide;
   logic                           clamp_on;
   logic [rsl_pkg::ValueWidth:0]   upper;
   logic [rsl_pkg::ValueWidth-1:0] lower;
   logic [rsl_pkg::ValueWidth-1:0] limited;

   always_comb begin
      range_change = req.range != prev_range_ff;
      mask_base    = range_change ? cfg.mask_count : mask_left_ff;
      smooth_base  = range_change ? cfg.smooth_count : smooth_left_ff;
      if (range_change) begin
         step_base = (cfg.smooth_count != '0) ? cfg.small_step : cfg.large_step;
      end else begin
         step_base = step_now_ff;
      end

      if (smooth_base != '0) begin
         smooth_next = smooth_base - 1'b1;
         step_eff    = (smooth_next == '0) ? cfg.large_step : step_base;
      end else begin
         smooth_next = '0;
         step_eff    = step_base;
      end

      step_wide = {{(rsl_pkg::ValueWidth-rsl_pkg::StepWidth){1'b0}}, step_eff};
      clamp_on  = have_first_ff && (kept_value_ff > step_wide);
      upper     = {1'b0, kept_value_ff} + {1'b0, step_wide};
      lower     = kept_value_ff - step_wide;

      limited = req.resistance;
      if (clamp_on) begin
         priority if ({1'b0, req.resistance} > upper) begin
            limited = upper[rsl_pkg::ValueWidth-1:0];
         end else if (req.resistance < lower) begin
            limited = lower;
         end
      end

      res_valid = fire && (req.kind == rsl_pkg::KindSample);
      if (mask_base != '0) begin
         res.limited_value = rsl_pkg::MarkerCode;
         res.masked        = 1'b1;
      end else begin
         res.limited_value = limited;
         res.masked        = 1'b0;
      end

      prev_range_in  = prev_range_ff;
      have_first_in  = have_first_ff;
      mask_left_in   = mask_left_ff;
      smooth_left_in = smooth_left_ff;
      step_now_in    = step_now_ff;
      kept_value_in  = kept_value_ff;
      if (fire) begin
         if (req.kind == rsl_pkg::KindRestart) begin
            prev_range_in  = req.range;
            have_first_in  = 1'b0;
            mask_left_in   = cfg.mask_count;
            smooth_left_in = '0;
            step_now_in    = cfg.large_step;
            kept_value_in  = rsl_pkg::StartValue;
         end else begin
            prev_range_in  = req.range;
            have_first_in  = 1'b1;
            mask_left_in   = (mask_base != '0) ? mask_base - 1'b1 : '0;
            smooth_left_in = smooth_next;
            step_now_in    = step_eff;
            kept_value_in  = limited;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_range_ff  <= '0;
         have_first_ff  <= 1'b0;
         mask_left_ff   <= rsl_pkg::MaskCountReset;
         smooth_left_ff <= '0;
         step_now_ff    <= rsl_pkg::LargeStepReset;
         kept_value_ff  <= rsl_pkg::StartValue;
      end else begin
         prev_range_ff  <= prev_range_in;
         have_first_ff  <= have_first_in;
         mask_left_ff   <= mask_left_in;
         smooth_left_ff <= smooth_left_in;
         step_now_ff    <= step_now_in;
         kept_value_ff  <= kept_value_in;
      end
   end

   `RSL_ASSERT_NEXT(a_sample_arms, clock, reset, res_valid, have_first_ff, "sample did not arm")
   `RSL_ASSERT_NEXT(a_restart_rearms, clock, reset,
      fire && (req.kind == rsl_pkg::KindRestart),
      (kept_value_ff == rsl_pkg::StartValue) && !have_first_ff &&
      (mask_left_ff == $past(cfg.mask_count)), "restart did not re-arm")
   `RSL_ASSERT_IMP(a_unmasked_value, clock, reset,
      res_valid && !range_change && (mask_left_ff == '0),
      !res.masked && (res.limited_value == limited), "unexpected masking")

endmodule

// File: src/rsl_out.sv
// ----------------------------------------------------------------------------
// Resistance slew limiter result register
// Holds one result until the result channel takes it.
// ----------------------------------------------------------------------------
module rsl_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             res_valid,
   input  rsl_pkg::rsp_type res,
   output logic             free,
   rsl_rsp_if.source        rsp_bus
);

   logic             valid_ff, valid_in;
   rsl_pkg::rsp_type data_ff, data_in;

   assign free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (free) begin
         valid_in = res_valid;
         if (res_valid) begin
            data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.limited_value = data_ff.limited_value;
   assign rsp_bus.masked        = data_ff.masked;

endmodule

// File: src/resistance_slew_limiter.sv
// ----------------------------------------------------------------------------
// Resistance slew limiter
// Limits the change between successive resistance samples and masks the
// outputs that follow a range change or restart.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle and presents its result in the
// following cycle from a single result register; a sample request yields one
// result and a restart request yields none. A request is taken whenever the
// result register is empty or its result is being taken in the same cycle,
// so throughput is one request per cycle while the result channel keeps up.
// Register writes take effect at the next reload of the step or counters: a
// range change, a restart or the end of a smoothing period.
module resistance_slew_limiter (
   input  logic      clock,
   input  logic      reset,
   rsl_req_if.sink   req_bus,
   rsl_rsp_if.source rsp_bus,
   rsl_csr_if.sink   csr_bus
);

   rsl_pkg::cfg_type cfg;
   rsl_pkg::req_type req;
   rsl_pkg::rsp_type res;
   logic             res_valid;
   logic             free;
   logic             fire;

   assign req_bus.ready = free;
   assign fire          = req_bus.valid && free;
   assign req.kind       = req_bus.kind;
   assign req.resistance = req_bus.resistance;
   assign req.range      = req_bus.range;

   rsl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   rsl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .req       (req),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   rsl_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .free      (free),
      .rsp_bus   (rsp_bus)
   );

endmodule

// File: bench/resistance_slew_limiter_test.sv
// ----------------------------------------------------------------------------
// Resistance slew limiter testbench
// Drives sample and restart requests through the limiter under several
// register settings. Each request is predicted on acceptance, and every
// result is checked field by field against the oldest prediction. Both
// channels stall at random, with one phase that runs without stalls.
// ----------------------------------------------------------------------------
module resistance_slew_limiter_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsl_req_if req_bus ();
   rsl_rsp_if rsp_bus ();
   rsl_csr_if csr_bus ();

   resistance_slew_limiter i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   rsl_pkg::req_type pending_reqs[$];
   rsl_pkg::rsp_type expected_results[$];
   int unsigned      idle_pct = 31;

   int unsigned mismatches      = 0;
   int unsigned results_checked = 0;
   int unsigned masked_seen     = 0;
   int unsigned samples_sent    = 0;
   int unsigned restarts_sent   = 0;
   int unsigned settings_used   = 0;

   rsl_pkg::cfg_type               limiter_regs;
   logic [rsl_pkg::RangeWidth-1:0] last_range;
   bit                             seen_first;
   logic [rsl_pkg::CountWidth-1:0] mask_left;
   logic [rsl_pkg::CountWidth-1:0] smooth_left;
   logic [rsl_pkg::StepWidth-1:0]  step_now;
   logic [rsl_pkg::ValueWidth-1:0] kept_value;

   logic [rsl_pkg::RangeWidth-1:0] gen_range = '0;
   longint                         gen_level = 64'd10_000_000;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void rearm_limiter(input logic [rsl_pkg::RangeWidth-1:0] rng);
      last_range  = rng;
      seen_first  = 1'b0;
      mask_left   = limiter_regs.mask_count;
      smooth_left = '0;
      step_now    = limiter_regs.large_step;
      kept_value  = rsl_pkg::StartValue;
   endfunction

   function automatic bit limit_sample(input rsl_pkg::req_type rq,
                                       output rsl_pkg::rsp_type rs);
      logic [rsl_pkg::ValueWidth:0]   upper;
      logic [rsl_pkg::ValueWidth-1:0] lower;
      logic [rsl_pkg::ValueWidth-1:0] value;
      value = rq.resistance;
      rs    = '0;
      if (rq.kind == rsl_pkg::KindRestart) begin
         rearm_limiter(rq.range);
         return 1'b0;
      end
      if (rq.range != last_range) begin
         mask_left   = limiter_regs.mask_count;
         smooth_left = limiter_regs.smooth_count;
         step_now    = (limiter_regs.smooth_count != '0) ? limiter_regs.small_step
                                                         : limiter_regs.large_step;
         last_range  = rq.range;
      end
      if (smooth_left != '0) begin
         smooth_left = smooth_left - 1'b1;
         if (smooth_left == '0) begin
            step_now = limiter_regs.large_step;
         end
      end
      if (seen_first && kept_value > {8'd0, step_now}) begin
         upper = {1'b0, kept_value} + {9'd0, step_now};
         lower = kept_value - {8'd0, step_now};
         if ({1'b0, value} > upper) begin
            value = upper[rsl_pkg::ValueWidth-1:0];
         end else if (value < lower) begin
            value = lower;
         end
      end else begin
         seen_first = 1'b1;
      end
      kept_value = value;
      if (mask_left != '0) begin
         mask_left        = mask_left - 1'b1;
         rs.limited_value = rsl_pkg::MarkerCode;
         rs.masked        = 1'b1;
      end else begin
         rs.limited_value = value;
         rs.masked        = 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [rsl_pkg::ValueWidth-1:0] want,
                                  input logic [rsl_pkg::ValueWidth-1:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("Mismatch in %s at %0t: expected %h, got %h", what, $realtime, want, got);
      end
   endtask

   // Register copy and limiter state follow every accepted write and request.
   always @(posedge clock) begin
      rsl_pkg::rsp_type predicted;
      if (reset) begin
         limiter_regs = '{rsl_pkg::LargeStepReset, rsl_pkg::SmallStepReset,
                          rsl_pkg::SmoothCountReset, rsl_pkg::MaskCountReset};
         rearm_limiter('0);
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               rsl_pkg::RegLargeStep:   limiter_regs.large_step = csr_bus.data;
               rsl_pkg::RegSmallStep:   limiter_regs.small_step = csr_bus.data;
               rsl_pkg::RegSmoothCount: begin
                  limiter_regs.smooth_count = csr_bus.data[rsl_pkg::CountWidth-1:0];
               end
               rsl_pkg::RegMaskCount: begin
                  limiter_regs.mask_count = csr_bus.data[rsl_pkg::CountWidth-1:0];
               end
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.kind == rsl_pkg::KindRestart) begin
               restarts_sent++;
            end else begin
               samples_sent++;
            end
            if (limit_sample({req_bus.kind, req_bus.resistance, req_bus.range}, predicted)) begin
               expected_results.push_back(predicted);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsl_pkg::req_type next_req;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_req = pending_reqs.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.kind       <= next_req.kind;
            req_bus.resistance <= next_req.resistance;
            req_bus.range      <= next_req.range;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsl_pkg::rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_bus.limited_value);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (rsp_bus.masked) begin
                  masked_seen++;
               end
               if (rsp_bus.limited_value !== want.limited_value) begin
                  report_mismatch("limited_value", want.limited_value, rsp_bus.limited_value);
               end
               if (rsp_bus.masked !== want.masked) begin
                  report_mismatch("masked", {31'd0, want.masked}, {31'd0, rsp_bus.masked});
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic wait_until_drained();
      while (pending_reqs.size() != 0 || req_bus.valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic load_registers(input rsl_pkg::cfg_type regs);
      logic [rsl_pkg::IndexWidth-1:0] reg_index [4];
      logic [rsl_pkg::StepWidth-1:0]  reg_data [4];
      reg_index = '{rsl_pkg::RegLargeStep, rsl_pkg::RegSmallStep,
                    rsl_pkg::RegSmoothCount, rsl_pkg::RegMaskCount};
      reg_data  = '{regs.large_step, regs.small_step,
                    {16'd0, regs.smooth_count}, {16'd0, regs.mask_count}};
      csr_bus.valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_bus.index <= reg_index[i];
         csr_bus.data  <= reg_data[i];
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // Mostly a random walk around the last level, so that clamping and the
   // step limits are exercised, mixed with range changes, restarts and jumps.
   task automatic queue_random_requests(input int unsigned count,
                                        input logic [rsl_pkg::StepWidth-1:0] step);
      rsl_pkg::req_type rq;
      longint           spread;
      int unsigned      pick;
      spread = 2 * longint'(step) + 16;
      for (int unsigned n = 0; n < count; n++) begin
         pick          = $urandom_range(99);
         rq.kind       = rsl_pkg::KindSample;
         rq.resistance = $urandom;
         if (pick < 4) begin
            rq.kind   = rsl_pkg::KindRestart;
            gen_range = 2'($urandom_range(3));
            gen_level = longint'(rsl_pkg::StartValue);
         end else begin
            if (pick < 10) begin
               gen_range = 2'($urandom_range(3));
            end
            case ($urandom_range(9))
               0: gen_level = longint'($urandom);
               1: gen_level = $urandom_range(1) ? 64'hFFFF_FFFF : 64'd0;
               default: gen_level += longint'($urandom_range(32'(2 * spread))) - spread;
            endcase
            if (gen_level < 0) begin
               gen_level = 0;
            end else if (gen_level > 64'hFFFF_FFFF) begin
               gen_level = 64'hFFFF_FFFF;
            end
            rq.resistance = gen_level[rsl_pkg::ValueWidth-1:0];
         end
         rq.range = gen_range;
         pending_reqs.push_back(rq);
      end
   endtask

   initial begin
      rsl_pkg::cfg_type phase_regs;
      req_bus.valid      = 1'b0;
      req_bus.kind       = rsl_pkg::KindSample;
      req_bus.resistance = '0;
      req_bus.range      = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = rsl_pkg::RegLargeStep;
      csr_bus.data       = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: first sample, extremes, both clamps, range changes, restarts.
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd0,          2'd0});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'hFFFF_FFFF,  2'd0});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd0,          2'd0});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'hFFFF_FFFF,  2'd0});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd12_000_000, 2'd0});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd12_000_000, 2'd0});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd0,          2'd0});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'hFFFF_FFFF,  2'd0});
      pending_reqs.push_back('{rsl_pkg::KindRestart, 32'hFFFF_FFFF,  2'd0});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd3_000,      2'd0});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd9_000,      2'd0});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd100,        2'd0});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd4_200,      2'd1});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd4_500,      2'd1});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd3_000,      2'd2});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd3_000,      2'd3});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd8_000,      2'd3});
      pending_reqs.push_back('{rsl_pkg::KindRestart, 32'd0,          2'd2});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd7_777,      2'd2});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd20_000,     2'd2});
      pending_reqs.push_back('{rsl_pkg::KindRestart, 32'h5555_AAAA,  2'd3});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd1,          2'd0});
      pending_reqs.push_back('{rsl_pkg::KindSample,  32'd90_000,     2'd0});
      wait_until_drained();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: phase_regs = '{24'd0, 24'd0, 8'd0, 8'd0};
            1: phase_regs = '{24'hFF_FFFF, 24'hFF_FFFF, 8'd255, 8'd255};
            2: phase_regs = '{24'd5_000, 24'd100, 8'd3, 8'd2};
            4: phase_regs = '{24'd1, 24'hFF_FFFF, 8'd1, 8'd1};
            default: begin
               phase_regs.large_step   = 24'($urandom_range(24'hFF_FFFF));
               phase_regs.small_step   = 24'($urandom_range(24'hFF_FFFF));
               phase_regs.smooth_count = 8'($urandom_range(20));
               phase_regs.mask_count   = 8'($urandom_range(10));
            end
         endcase
         load_registers(phase_regs);
         idle_pct = (p == 3) ? 0 : 31;
         queue_random_requests(105, phase_regs.large_step);
         wait_until_drained();
      end

      $display("Covered %0d sample and %0d restart requests under %0d register settings.",
               samples_sent, restarts_sent, settings_used + 1);
      $display("Checked %0d results, %0d of them masked, with %0d mismatches.",
               results_checked, masked_seen, mismatches);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Timed out with %0d results outstanding.", expected_results.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
